[src/pru_pkg.sv]
// Shared types, widths, operation codes and the factorial table of the
// permutation rank/unrank core. No dependencies.
package pru_pkg;

    localparam int RANK_W         = 33;
    localparam int ELEM_W         = 4;
    localparam int PLEN_W         = 4;
    localparam int LEN_W          = 5;
    localparam int FACT_W         = 64;
    localparam int MAX_LENGTH_DEF = 13;
    localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(13);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic              kind;
        logic [RANK_W-1:0] rank;
        logic [ELEM_W-1:0] elem;
        logic              last;
        logic              error;
    } result_t;

    function automatic logic [FACT_W-1:0] fact_full(input logic [LEN_W-1:0] idx);
        logic [FACT_W-1:0] f;
        unique case (idx)
            5'd0:    f = 64'd1;
            5'd1:    f = 64'd1;
            5'd2:    f = 64'd2;
            5'd3:    f = 64'd6;
            5'd4:    f = 64'd24;
            5'd5:    f = 64'd120;
            5'd6:    f = 64'd720;
            5'd7:    f = 64'd5040;
            5'd8:    f = 64'd40320;
            5'd9:    f = 64'd362880;
            5'd10:   f = 64'd3628800;
            5'd11:   f = 64'd39916800;
            5'd12:   f = 64'd479001600;
            5'd13:   f = 64'd6227020800;
            5'd14:   f = 64'd87178291200;
            5'd15:   f = 64'd1307674368000;
            5'd16:   f = 64'd20922789888000;
            5'd17:   f = 64'd355687428096000;
            5'd18:   f = 64'd6402373705728000;
            5'd19:   f = 64'd121645100408832000;
            5'd20:   f = 64'd2432902008176640000;
            default: f = 64'd1;
        endcase
        return f;
    endfunction

endpackage

[src/pru_alu.sv]
// Shared 33-bit add / compare-subtract unit of the permutation rank/unrank core.
// Depends on pru_pkg.
module pru_alu
(
    input  pru_pkg::alu_op_t                op,
    input  logic [pru_pkg::RANK_W-1:0]      a,
    input  logic [pru_pkg::RANK_W-1:0]      b,
    input  logic                            b_big,
    output logic [pru_pkg::RANK_W-1:0]      res,
    output logic                            ge
);
    import pru_pkg::*;

    logic              is_sub;
    logic [RANK_W-1:0] b_op;
    logic [RANK_W:0]   total;

    assign is_sub = (op == ALU_SUB);
    assign b_op   = is_sub ? ~b : b;
    assign total  = {1'b0, a} + {1'b0, b_op} + {{RANK_W{1'b0}}, is_sub};
    assign res    = total[RANK_W-1:0];
    assign ge     = is_sub & total[RANK_W] & ~b_big;

endmodule

[src/pru_outreg.sv]
// Output register of the permutation rank/unrank core: holds one result
// transaction until the receiver takes it. Depends on pru_pkg.
module pru_outreg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_valid,
    input  pru_pkg::result_t            load_data,
    output logic                        load_ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pru_pkg::result_t            out_data
);
    import pru_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign load_ready = ~valid_reg | ~out_stall;
    assign valid_next = load_valid | (valid_reg & out_stall);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            data_reg <= load_data;
        end
    end

endmodule

[src/permutation_rank_unrank_core.sv]
// Permutation rank/unrank core: top level with the slot-scan sequencer.
// Depends on pru_pkg, pru_alu and pru_outreg.
//
// Input channel (in_valid/in_stall): command 0 feeds one permutation element,
// command 1 decodes rank_value into a permutation. The core takes one
// transaction at a time; in_stall is high while a transaction is in work
// and during a configuration write.
// Output channel (out_valid/out_stall): kind 0 carries a rank, kind 1 an
// element; last marks the final result of a transaction, error a bad element
// or a rank of N! or more. A result waits in an output register, so a
// stalled receiver delays the core only when a second result is ready.
// Sequence: a fed element runs a slot scan that adds one factorial per free
// lower slot through the shared adder; after the N-th element the rank is
// emitted. A decode first checks rank_value against N!, then for each
// element scans the slots (at most N) and emits the element it finds.
// cfg_wr_en/cfg_wr_data write N (perm_length) while the core is idle and
// drop a half-loaded permutation. Reset sets N to 13 and clears the load
// state and output.
module permutation_rank_unrank_core
#(
    parameter int MAX_LENGTH = pru_pkg::MAX_LENGTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pru_pkg::PLEN_W-1:0]      cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [pru_pkg::ELEM_W-1:0]      element,
    input  logic [pru_pkg::RANK_W-1:0]      rank_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kind,
    output logic [pru_pkg::RANK_W-1:0]      rank_out,
    output logic [pru_pkg::ELEM_W-1:0]      element_out,
    output logic                            last,
    output logic                            error
);
    import pru_pkg::*;

    localparam int SLOT_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENC  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]            state_reg,    state_next;
    logic [PLEN_W-1:0]     plen_reg,     plen_next;
    logic [MAX_LENGTH-1:0] used_reg,     used_next;
    logic [LEN_W-1:0]      pos_reg,      pos_next;
    logic [RANK_W-1:0]     acc_reg,      acc_next;
    logic [SLOT_W-1:0]     slot_reg,     slot_next;
    logic [ELEM_W-1:0]     elem_reg,     elem_next;
    result_t               res_reg,      res_next;

    logic [LEN_W-1:0]      len_eff;
    logic [LEN_W-1:0]      fact_idx;
    logic [FACT_W-1:0]     fact_val;
    alu_op_t               alu_op;
    logic [RANK_W-1:0]     alu_res;
    logic                  alu_ge;
    logic                  in_take;
    logic                  elem_used;
    logic                  push_valid;
    logic                  push_ready;
    result_t               out_data;

    always_comb
    begin
        if (plen_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (LEN_W'(plen_reg) > LEN_W'(MAX_LENGTH))
        begin
            len_eff = LEN_W'(MAX_LENGTH);
        end
        else
        begin
            len_eff = LEN_W'(plen_reg);
        end
    end

    always_comb
    begin
        elem_used = 1'b0;
        for (int s = 0; s < MAX_LENGTH; s++)
        begin
            if (LEN_W'(s) == LEN_W'(element))
            begin
                elem_used = elem_used | used_reg[s];
            end
        end
    end

    assign fact_idx = (state_reg == ST_CHK) ? len_eff : (len_eff - LEN_W'(1) - pos_reg);
    assign fact_val = fact_full(fact_idx);
    assign alu_op   = (state_reg == ST_ENC) ? ALU_ADD : ALU_SUB;

    pru_alu u_alu
    (
        .op    (alu_op),
        .a     (acc_reg),
        .b     (fact_val[RANK_W-1:0]),
        .b_big (|fact_val[FACT_W-1:RANK_W]),
        .res   (alu_res),
        .ge    (alu_ge)
    );

    assign in_stall   = (state_reg != ST_IDLE) | cfg_wr_en;
    assign in_take    = in_valid & ~in_stall;
    assign push_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        plen_next  = plen_reg;
        used_next  = used_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        slot_next  = slot_reg;
        elem_next  = elem_reg;
        res_next   = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    plen_next = cfg_wr_data;
                    used_next = '0;
                    pos_next  = '0;
                    acc_next  = '0;
                end
                else if (in_take)
                begin
                    slot_next = '0;
                    elem_next = element;
                    if (command == 1'b0)
                    begin
                        if ((LEN_W'(element) >= len_eff) || elem_used)
                        begin
                            res_next   = '{kind: 1'b0, rank: '0, elem: '0,
                                           last: 1'b1, error: 1'b1};
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_ENC;
                        end
                    end
                    else
                    begin
                        used_next  = '0;
                        pos_next   = '0;
                        acc_next   = rank_value;
                        state_next = ST_CHK;
                    end
                end
            end

            ST_ENC:
            begin
                if (LEN_W'(slot_reg) == LEN_W'(elem_reg))
                begin
                    used_next[slot_reg] = 1'b1;
                    pos_next            = pos_reg + LEN_W'(1);
                    if ((pos_reg + LEN_W'(1)) == len_eff)
                    begin
                        res_next   = '{kind: 1'b0, rank: acc_reg, elem: '0,
                                       last: 1'b1, error: 1'b0};
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (!used_reg[slot_reg])
                    begin
                        acc_next = alu_res;
                    end
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            ST_CHK:
            begin
                if (alu_ge)
                begin
                    res_next   = '{kind: 1'b1, rank: '0, elem: '0,
                                   last: 1'b1, error: 1'b1};
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DEC;
                end
            end

            ST_DEC:
            begin
                if (used_reg[slot_reg])
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                else if (alu_ge)
                begin
                    acc_next  = alu_res;
                    slot_next = slot_reg + SLOT_W'(1);
                end
                else
                begin
                    used_next[slot_reg] = 1'b1;
                    pos_next            = pos_reg + LEN_W'(1);
                    slot_next           = '0;
                    res_next            = '{kind: 1'b1, rank: '0,
                                            elem: ELEM_W'(slot_reg),
                                            last: (pos_reg == (len_eff - LEN_W'(1))),
                                            error: 1'b0};
                    state_next          = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (push_ready)
                begin
                    if (res_reg.last)
                    begin
                        used_next  = '0;
                        pos_next   = '0;
                        acc_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DEC;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plen_reg  <= PLEN_RESET;
            used_reg  <= '0;
            pos_reg   <= '0;
            acc_reg   <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plen_reg  <= plen_next;
            used_reg  <= used_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        res_reg  <= res_next;
    end

    pru_outreg u_outreg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (push_valid),
        .load_data  (res_reg),
        .load_ready (push_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign kind        = out_data.kind;
    assign rank_out    = out_data.rank;
    assign element_out = out_data.elem;
    assign last        = out_data.last;
    assign error       = out_data.error;

endmodule
